@@ hdl/spst_pkg.sv @@
// Shared constants, codes and types for the scanline polygon span table.
`timescale 1ns / 1ps

package spst_pkg;

    // Table geometry and fixed-point format.
    localparam int LINES     = 512;
    localparam int WIDTH     = 512;
    localparam int FRAC_BITS = 8;

    // Fixed field widths of the request and result items.
    localparam int COORD_W = 9;
    localparam int REQ_W   = 2;
    localparam int SPAN_W  = 10;

    // Derived widths.
    localparam int ADDR_W    = $clog2(LINES);
    localparam int Y_W       = COORD_W + 1;
    localparam int DVD_W     = COORD_W + FRAC_BITS;
    localparam int POS_W     = DVD_W + 2;
    localparam int CLR_VAL   = WIDTH * (2 ** FRAC_BITS);
    localparam int CLR_W     = $clog2(CLR_VAL + 1);
    localparam int BND_W     = (CLR_W > DVD_W) ? CLR_W : DVD_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int ROUND_UP  = (2 ** FRAC_BITS) - 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_WALK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [BND_W-1:0] left;
        logic [BND_W-1:0] right;
    } t_entry;

endpackage

@@ hdl/spst_div.sv @@
// Restoring divider that forms the unsigned edge slope one quotient bit per cycle.
`timescale 1ns / 1ps

module spst_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spst_pkg::DVD_W-1:0]   i_dividend,
    input  logic [spst_pkg::COORD_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [spst_pkg::DVD_W-1:0]   o_quotient
);
    import spst_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_rem;
    logic [COORD_W-1:0]   r_dsr;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVD_W-1:0]     r_quo;

    logic [COORD_W:0]     trial;
    logic [COORD_W:0]     diff;
    logic                 fits;
    logic                 last;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = (trial >= {1'b0, r_dsr});
    assign last  = (r_cnt == DIV_CNT_W'(DVD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTH
    a_div_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_divisor != '0))
        else $error("divider started with a zero divisor");

    a_div_no_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_div_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dsr))
        else $error("partial remainder not below divisor");

    a_div_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

@@ hdl/scanline_polygon_span_table.sv @@
// Top level of the scanline polygon span table: sequencer, bound memory and edge walker.
`timescale 1ns / 1ps
// Sequence: a query or an unused code reads the table and then returns its result; a clear
// writes every scanline; an edge runs the divider unless it is horizontal, then walks its
// dy + 1 scanlines; the walk does one scanline read-modify-write per cycle.
// Throughput: one item at a time; busy stays high until the item is finished.
// Reset: synchronous active-low; afterwards a clearing pass fills the table with busy high.
// Results are one-cycle strobes, and the receiver cannot stall them.

module scanline_polygon_span_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [spst_pkg::REQ_W-1:0]   i_req_type,
    input  logic [spst_pkg::COORD_W-1:0] i_x_start,
    input  logic [spst_pkg::COORD_W-1:0] i_y_start,
    input  logic [spst_pkg::COORD_W-1:0] i_x_end,
    input  logic [spst_pkg::COORD_W-1:0] i_y_end,
    input  logic [spst_pkg::COORD_W-1:0] i_query_line,
    output logic                        o_strobe,
    output logic [spst_pkg::COORD_W-1:0] o_scan_line,
    output logic                        o_span_valid,
    output logic [spst_pkg::SPAN_W-1:0]  o_span_start,
    output logic [spst_pkg::SPAN_W-1:0]  o_span_end
);
    import spst_pkg::*;

    // Sequencer and control registers.
    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_cnt;
    logic                r_clr_req;
    logic                r_wb_vld;
    logic                r_strobe;

    // Item registers.
    logic [REQ_W-1:0]    r_req;
    logic [COORD_W-1:0]  r_ql;
    logic                r_ql_ok;
    logic                r_neg;
    logic [Y_W-1:0]      r_y;
    logic [COORD_W-1:0]  r_y1;
    logic signed [POS_W-1:0] r_pos;
    logic signed [POS_W-1:0] r_slope;
    logic [ADDR_W-1:0]   r_wb_addr;
    logic [BND_W-1:0]    r_wb_x;

    // Result registers.
    logic [COORD_W-1:0]  r_scan_line;
    logic                r_span_valid;
    logic [SPAN_W-1:0]   r_span_start;
    logic [SPAN_W-1:0]   r_span_end;
    logic                n_strobe;
    logic [COORD_W-1:0]  n_scan_line;
    logic                n_span_valid;
    logic [SPAN_W-1:0]   n_span_start;
    logic [SPAN_W-1:0]   n_span_end;

    // Bound memory: one word per scanline holding both bounds.
    t_entry              mem [LINES];
    t_entry              r_rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_entry              wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    // Request decode and endpoint ordering.
    logic                accept;
    logic                swap;
    logic [COORD_W-1:0]  x0;
    logic [COORD_W-1:0]  y0;
    logic [COORD_W-1:0]  x1;
    logic [COORD_W-1:0]  y1;
    logic                dx_neg;
    logic [COORD_W-1:0]  dx_mag;
    logic [COORD_W-1:0]  dy;
    logic                dy_zero;
    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;
    logic signed [POS_W-1:0] quo_ext;

    // Walk and query helpers.
    logic                issue;
    logic                y_in_table;
    t_entry              merged;
    logic [BND_W-1:0]    left_px;
    logic [BND_W:0]      right_sum;
    logic [BND_W:0]      right_px;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // The edge always runs toward increasing y.
    assign swap    = (i_y_start > i_y_end);
    assign x0      = swap ? i_x_end   : i_x_start;
    assign y0      = swap ? i_y_end   : i_y_start;
    assign x1      = swap ? i_x_start : i_x_end;
    assign y1      = swap ? i_y_start : i_y_end;
    assign dx_neg  = (x1 < x0);
    assign dx_mag  = dx_neg ? (x0 - x1) : (x1 - x0);
    assign dy      = y1 - y0;
    assign dy_zero = (dy == '0);

    // A horizontal edge needs no slope; it walks its single line with a zero step.
    assign div_start = accept && (i_req_type == REQ_EDGE) && !dy_zero;

    spst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({dx_mag, {FRAC_BITS{1'b0}}}),
        .i_divisor  (dy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign quo_ext = signed'({2'b00, div_quo});

    // The walk issues one line read per cycle while the previous line is written back.
    assign issue      = ({1'b0, r_y1} >= r_y);
    assign y_in_table = (32'(r_y) < LINES);

    assign merged.left  = (r_wb_x < r_rd_data.left)  ? r_wb_x : r_rd_data.left;
    assign merged.right = (r_wb_x > r_rd_data.right) ? r_wb_x : r_rd_data.right;

    // Pixel span: floor of the left bound and ceiling of the right bound.
    assign left_px   = r_rd_data.left >> FRAC_BITS;
    assign right_sum = {1'b0, r_rd_data.right} + (BND_W + 1)'(ROUND_UP);
    assign right_px  = right_sum >> FRAC_BITS;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_cnt == ADDR_W'(LINES - 1)) begin
                    n_state = r_clr_req ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        REQ_CLEAR: n_state = S_CLR;
                        REQ_EDGE:  n_state = dy_zero ? S_WALK : S_DIV;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!issue && !r_wb_vld) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output and memory-port logic.
    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = r_wb_addr;
        wr_data      = merged;
        rd_addr      = ADDR_W'(i_query_line);
        n_strobe     = 1'b0;
        n_scan_line  = '0;
        n_span_valid = 1'b0;
        n_span_start = '0;
        n_span_end   = '0;
        unique case (r_state)
            S_CLR: begin
                wr_en         = 1'b1;
                wr_addr       = r_cnt;
                wr_data.left  = BND_W'(CLR_VAL);
                wr_data.right = '0;
            end
            S_IDLE: begin
                rd_addr = ADDR_W'(i_query_line);
            end
            S_DIV: begin
                rd_addr = ADDR_W'(r_y);
            end
            S_WALK: begin
                rd_addr = ADDR_W'(r_y);
                wr_en   = r_wb_vld;
            end
            S_RESP: begin
                n_strobe = 1'b1;
                if (r_req == REQ_QUERY) begin
                    n_scan_line = r_ql;
                    if (r_ql_ok && (r_rd_data.left < r_rd_data.right)) begin
                        n_span_valid = 1'b1;
                        n_span_start = SPAN_W'(left_px);
                        n_span_end   = SPAN_W'(right_px);
                    end
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_clr_req <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_wb_vld <= (r_state == S_WALK) && issue && y_in_table;
            if (r_state == S_CLR) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (accept) begin
                r_clr_req <= (i_req_type == REQ_CLEAR);
            end
        end
    end

    // Item and walk registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_ql    <= i_query_line;
            r_ql_ok <= (32'(i_query_line) < LINES);
            r_neg   <= dx_neg;
            r_y     <= {1'b0, y0};
            r_y1    <= y1;
            r_pos   <= signed'({2'b00, x0, {FRAC_BITS{1'b0}}});
            r_slope <= '0;
        end else if ((r_state == S_DIV) && div_done) begin
            r_slope <= r_neg ? -quo_ext : quo_ext;
        end else if ((r_state == S_WALK) && issue) begin
            r_pos     <= r_pos + r_slope;
            r_y       <= r_y + 1'b1;
            r_wb_addr <= ADDR_W'(r_y);
            r_wb_x    <= BND_W'(r_pos[DVD_W-1:0]);
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        r_scan_line  <= n_scan_line;
        r_span_valid <= n_span_valid;
        r_span_start <= n_span_start;
        r_span_end   <= n_span_end;
    end

    // Bound memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_strobe     = r_strobe;
    assign o_scan_line  = r_scan_line;
    assign o_span_valid = r_span_valid;
    assign o_span_start = r_span_start;
    assign o_span_end   = r_span_end;

`ifndef SYNTH
    a_single_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    a_result_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while an item is still in progress");

    a_accept_goes_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not make the block busy");

    a_writeback_in_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> (r_state == S_WALK))
        else $error("bound write-back outside the edge walk");
`endif

endmodule
